// ===== rtl/arr_pkg.sv =====
// Shared types, sizes and codes for the address range registry.
package arr_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int ADDR_W   = 64;
  localparam int ENTRY_W  = 2 * ADDR_W;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 5;
  localparam int OUT_W    = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_OVERLAP  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH,
    S_REPLY
  } state_t;

endpackage

// ===== rtl/arr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module arr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/address_range_registry.sv =====
// Top level of the address range registry: range table, scan sequencer and ports.
//
//  channel | direction | handshake              | contents
//  in_     | slave     | in_tvalid / in_tready  | tuser: command; tdata: start, size
//  out_    | master    | out_tvalid / out_tready| tdata: status, entries_used
//  cfg_    | slave     | cfg_valid / cfg_ready  | cfg_data: phys_limit
//
// A request goes from its beat to its result in these steps: the end-address add and
// limit compare, one RAM read per table slot through the single shared compare unit
// with registered read data, and then write-back and reply.
// A range error on an add skips the scan; a hit in the scan ends it early.
// Reset clears the valid marks and the count at once; the RAM itself is not cleared.
// in_tready is low while a request is in flight; a stalled result holds in the
// output register, and cfg_ready is always high.
module address_range_registry (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [arr_pkg::ENTRY_W-1:0] in_tdata,  // [63:0] range_start, [127:64] range_size
  input  logic [0:0]                 in_tuser,   // [0] command
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [arr_pkg::OUT_W-1:0]  out_tdata,  // [2:0] status, [7:3] entries_used
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [arr_pkg::ADDR_W-1:0] cfg_data
);

  localparam int IW = arr_pkg::IDX_W;
  localparam int AW = arr_pkg::ADDR_W;

  arr_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]            phys_limit_r;
  arr_pkg::cmd_t            cmd_r;
  logic [AW-1:0]            start_r, size_r, end_r;
  logic                     range_err_r;
  logic [IW:0]              iss_cnt_r;
  logic                     cmp_vld_r;
  logic [IW-1:0]            cmp_idx_r;
  logic                     hit_r;
  logic [IW-1:0]            hit_idx_r;
  logic                     free_fnd_r;
  logic [IW-1:0]            free_idx_r;
  logic [arr_pkg::ENTRIES-1:0] valid_r;
  logic [arr_pkg::CNT_W-1:0] cnt_r;
  arr_pkg::status_t         res_status_r;
  logic                     out_tvalid_r;
  logic [arr_pkg::OUT_W-1:0] out_tdata_r;

  logic                     in_beat;
  logic [AW:0]              end_sum;
  logic                     range_bad;
  logic [arr_pkg::ENTRY_W-1:0] rd_data;
  logic [AW-1:0]            ts, tsz, te;
  logic                     ovl, match, ent_v, cmp_hit, cmp_last;
  logic                     rd_en, ram_we, out_load;
  arr_pkg::status_t         status_nxt;

  assign in_beat   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // End address of the requested range, with the carry kept to spot a wrap.
  assign end_sum   = {1'b0, start_r} + {1'b0, size_r};
  assign range_bad = end_sum[AW] || (end_sum[AW-1:0] > phys_limit_r);

  // Shared compare unit, fed by one RAM entry per cycle.
  assign ts       = rd_data[AW-1:0];
  assign tsz      = rd_data[2*AW-1:AW];
  assign te       = ts + tsz;
  assign ovl      = !((start_r >= te) || (end_r <= ts));
  assign match    = (ts == start_r) && (tsz == size_r);
  assign ent_v    = valid_r[cmp_idx_r];
  assign cmp_hit  = cmp_vld_r && ent_v && ((cmd_r == arr_pkg::CMD_REMOVE) ? match : ovl);
  assign cmp_last = cmp_vld_r && (cmp_idx_r == IW'(arr_pkg::ENTRIES - 1));

  arr_ram #(
    .WIDTH(arr_pkg::ENTRY_W),
    .DEPTH(arr_pkg::ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_idx_r),
    .wdata({size_r, start_r}),
    .re   (rd_en),
    .raddr(iss_cnt_r[IW-1:0]),
    .rdata(rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arr_pkg::S_IDLE: begin
        if (in_beat) state_nxt = arr_pkg::S_CHECK;
      end
      arr_pkg::S_CHECK: begin
        if (range_bad && (cmd_r == arr_pkg::CMD_ADD)) state_nxt = arr_pkg::S_FINISH;
        else state_nxt = arr_pkg::S_SCAN;
      end
      arr_pkg::S_SCAN: begin
        if (cmp_hit || cmp_last) state_nxt = arr_pkg::S_FINISH;
      end
      arr_pkg::S_FINISH: begin
        state_nxt = arr_pkg::S_REPLY;
      end
      arr_pkg::S_REPLY: begin
        if (!out_tvalid_r || out_tready) state_nxt = arr_pkg::S_IDLE;
      end
      default: state_nxt = arr_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready  = 1'b0;
    rd_en      = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    status_nxt = arr_pkg::ST_OK;
    case (state_r)
      arr_pkg::S_IDLE: begin
        in_tready = 1'b1;
      end
      arr_pkg::S_SCAN: begin
        rd_en = (iss_cnt_r < (IW + 1)'(arr_pkg::ENTRIES)) && !cmp_hit;
      end
      arr_pkg::S_FINISH: begin
        if (cmd_r == arr_pkg::CMD_ADD) begin
          if (range_err_r) status_nxt = arr_pkg::ST_RANGE;
          else if (hit_r) status_nxt = arr_pkg::ST_OVERLAP;
          else if (!free_fnd_r) status_nxt = arr_pkg::ST_FULL;
          else begin
            status_nxt = arr_pkg::ST_OK;
            ram_we     = 1'b1;
          end
        end else begin
          status_nxt = hit_r ? arr_pkg::ST_OK : arr_pkg::ST_NOTFOUND;
        end
      end
      arr_pkg::S_REPLY: begin
        out_load = !out_tvalid_r || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= arr_pkg::S_IDLE;
      phys_limit_r <= '1;
      valid_r      <= '0;
      cnt_r        <= '0;
      cmp_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) phys_limit_r <= cfg_data;
      cmp_vld_r <= rd_en;

      if (state_r == arr_pkg::S_FINISH) begin
        if (ram_we) begin
          valid_r[free_idx_r] <= 1'b1;
          cnt_r               <= cnt_r + 1'b1;
        end else if ((cmd_r == arr_pkg::CMD_REMOVE) && hit_r) begin
          valid_r[hit_idx_r] <= 1'b0;
          cnt_r              <= cnt_r - 1'b1;
        end
      end

      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Request and scan datapath; these registers need no reset.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_r   <= arr_pkg::cmd_t'(in_tuser[0]);
      start_r <= in_tdata[AW-1:0];
      size_r  <= in_tdata[2*AW-1:AW];
    end
    if (state_r == arr_pkg::S_CHECK) begin
      end_r       <= end_sum[AW-1:0];
      range_err_r <= range_bad && (cmd_r == arr_pkg::CMD_ADD);
      iss_cnt_r   <= '0;
      hit_r       <= 1'b0;
      free_fnd_r  <= 1'b0;
    end
    if (rd_en) begin
      iss_cnt_r <= iss_cnt_r + 1'b1;
      cmp_idx_r <= iss_cnt_r[IW-1:0];
    end
    if ((state_r == arr_pkg::S_SCAN) && cmp_hit) begin
      hit_r     <= 1'b1;
      hit_idx_r <= cmp_idx_r;
    end
    // The first free slot seen in scan order is the lowest-numbered one.
    if ((state_r == arr_pkg::S_SCAN) && cmp_vld_r && !ent_v && !free_fnd_r) begin
      free_fnd_r <= 1'b1;
      free_idx_r <= cmp_idx_r;
    end
    if (state_r == arr_pkg::S_FINISH) res_status_r <= status_nxt;
    if (out_load) out_tdata_r <= {arr_pkg::USED_W'(cnt_r), res_status_r};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/arr_checker.sv =====
// Port-level assertions for the address range registry, bound to the top level.
module arr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [arr_pkg::OUT_W-1:0]   out_tdata
);

  // A request keeps the input side closed while it is worked on.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted a beat while a request was in flight");

  // A result beat cannot follow directly on the request that caused it.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_tvalid) |=> !out_tvalid)
    else $error("result appeared one cycle after a request beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result beat changed or dropped");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= arr_pkg::ST_FULL))
    else $error("result status outside the defined codes");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:3] <= arr_pkg::ENTRIES))
    else $error("entries_used exceeds table size");

endmodule

bind address_range_registry arr_checker u_arr_checker (.*);
